/* rtl/pca_pkg.sv */
// Package with shared types, codes and sizes of the pick code allocator.
package pca_pkg;

    localparam int unsigned CodeW    = 24;
    localparam int unsigned CountW   = 7;
    localparam int unsigned StatusW  = 2;
    localparam int unsigned PoolDepth = 4096;
    localparam int unsigned PoolAddrW = $clog2(PoolDepth);
    localparam int unsigned PoolCntW  = $clog2(PoolDepth + 1);

    localparam int unsigned MAX_CODE_DEFAULT  = 4095;
    localparam int unsigned MAX_BURST_DEFAULT = 64;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [StatusW-1:0] ST_OK        = 2'd0;
    localparam logic [StatusW-1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [StatusW-1:0] ST_BAD_FREE  = 2'd2;

    typedef struct packed {
        logic              opcode;
        logic [CountW-1:0] count;
        logic [CodeW-1:0]  code;
    } t_item;

    typedef struct packed {
        logic [CodeW-1:0]   code_out;
        logic [StatusW-1:0] status;
        logic               last;
    } t_result;

    typedef struct packed {
        logic alloc;
        logic free;
        logic last;
    } t_cmd;

endpackage

/* rtl/pca_ctrl.sv */
// Controller that accepts items and sequences the codes of an allocate burst.
module pca_ctrl #(
    parameter int unsigned MAX_BURST = pca_pkg::MAX_BURST_DEFAULT
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  pca_pkg::t_item i_item,
    output logic          o_busy,
    output pca_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_ALLOC = 2'b10
    } t_state;

    localparam logic [pca_pkg::CountW-1:0] BurstMax = pca_pkg::CountW'(MAX_BURST);

    t_state                     r_state, n_state;
    logic [pca_pkg::CountW-1:0] r_rem, n_rem;
    logic [pca_pkg::CountW-1:0] burst;
    logic                       accept;

    assign o_busy = (r_state == S_ALLOC);
    assign accept = i_start && (r_state == S_IDLE);
    assign burst  = (i_item.count > BurstMax) ? BurstMax : i_item.count;

    always_comb begin
        n_state = r_state;
        n_rem   = r_rem;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_item.opcode == pca_pkg::OP_FREE) begin
                        o_cmd.free = 1'b1;
                        o_cmd.last = 1'b1;
                    end else if (burst != '0) begin
                        o_cmd.alloc = 1'b1;
                        o_cmd.last  = (burst == pca_pkg::CountW'(1));
                        if (burst != pca_pkg::CountW'(1)) begin
                            n_state = S_ALLOC;
                            n_rem   = burst - pca_pkg::CountW'(1);
                        end
                    end
                end
            end
            S_ALLOC: begin
                o_cmd.alloc = 1'b1;
                o_cmd.last  = (r_rem == pca_pkg::CountW'(1));
                n_rem       = r_rem - pca_pkg::CountW'(1);
                if (r_rem == pca_pkg::CountW'(1)) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_rem   <= '0;
        end else begin
            r_state <= n_state;
            r_rem   <= n_rem;
        end
    end

endmodule

/* rtl/pca_datapath.sv */
// Datapath with the free pool memory, pool count, high-water counter and result register.
module pca_datapath #(
    parameter int unsigned MAX_CODE = pca_pkg::MAX_CODE_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  pca_pkg::t_cmd    i_cmd,
    input  logic [pca_pkg::CodeW-1:0] i_code,
    output logic             o_valid,
    output pca_pkg::t_result o_result
);

    localparam int unsigned HwW = (MAX_CODE < 2) ? 1 : $clog2(MAX_CODE + 1);
    localparam logic [HwW-1:0] HwMax = HwW'(MAX_CODE);
    localparam logic [pca_pkg::PoolCntW-1:0] PoolFull = pca_pkg::PoolCntW'(pca_pkg::PoolDepth);

    logic [HwW-1:0] r_pool [pca_pkg::PoolDepth];

    logic [pca_pkg::PoolCntW-1:0] r_cnt, n_cnt;
    logic [HwW-1:0]               r_hw, n_hw;
    logic                         r_out_vld;
    logic                         r_out_from_pool, n_out_from_pool;
    logic [pca_pkg::CodeW-1:0]    r_out_code, n_out_code;
    logic [pca_pkg::StatusW-1:0]  r_out_status, n_out_status;
    logic                         r_out_last;
    logic [HwW-1:0]               r_rdata;

    logic                          free_bad;
    logic                          push;
    logic [pca_pkg::PoolAddrW-1:0] push_addr;
    logic [pca_pkg::PoolAddrW-1:0] pop_addr;

    assign free_bad  = (i_code == '0) || (i_code > pca_pkg::CodeW'(r_hw)) || (r_cnt == PoolFull);
    assign push      = i_cmd.free && !free_bad;
    assign push_addr = r_cnt[pca_pkg::PoolAddrW-1:0];
    assign pop_addr  = pca_pkg::PoolAddrW'(r_cnt - pca_pkg::PoolCntW'(1));

    always_comb begin
        n_cnt           = r_cnt;
        n_hw            = r_hw;
        n_out_from_pool = 1'b0;
        n_out_code      = i_code;
        n_out_status    = pca_pkg::ST_OK;
        if (i_cmd.alloc) begin
            if (r_cnt != '0) begin
                n_cnt           = r_cnt - pca_pkg::PoolCntW'(1);
                n_out_from_pool = 1'b1;
            end else if (r_hw < HwMax) begin
                n_hw       = r_hw + HwW'(1);
                n_out_code = pca_pkg::CodeW'(n_hw);
            end else begin
                n_out_code   = '0;
                n_out_status = pca_pkg::ST_EXHAUSTED;
            end
        end else if (i_cmd.free) begin
            if (free_bad) begin
                n_out_status = pca_pkg::ST_BAD_FREE;
            end else begin
                n_cnt = r_cnt + pca_pkg::PoolCntW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_pool[push_addr] <= i_code[HwW-1:0];
        end
        if (i_cmd.alloc) begin
            r_rdata <= r_pool[pop_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt     <= '0;
            r_hw      <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_cnt     <= n_cnt;
            r_hw      <= n_hw;
            r_out_vld <= i_cmd.alloc || i_cmd.free;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_from_pool <= n_out_from_pool;
        r_out_code      <= n_out_code;
        r_out_status    <= n_out_status;
        r_out_last      <= i_cmd.last;
    end

    assign o_valid           = r_out_vld;
    assign o_result.code_out = r_out_from_pool ? pca_pkg::CodeW'(r_rdata) : r_out_code;
    assign o_result.status   = r_out_status;
    assign o_result.last     = r_out_last;

endmodule

/* rtl/pick_code_allocator.sv */
// Top level of the pick code allocator: hands out nonzero codes and takes them back.
//
// An item is taken at a rising edge with i_start high and o_busy low. A free item
// gives one result beat; an allocate item gives one beat per requested code, the
// count capped at MAX_BURST, and nothing at all for a count of zero. Each result
// beat stands on o_result for one cycle with o_valid high; the last beat of an item
// carries last. Freed codes come back first, newest first, and fresh codes follow
// from a high-water counter up to MAX_CODE.
// A beat appears the cycle after its code is issued, since the result and the pool
// read data are both registered. One code is issued per cycle, so an allocate item
// of n codes holds o_busy until its last code is issued and a free item never raises
// o_busy; the next item can be taken while the final beat shows.
// The single pool memory port pair (one push, one pop) sets this rate.
// Reset empties the pool and clears the high-water counter at once; no clearing
// pass is needed. The receiver cannot stall: every beat must be taken when shown.
module pick_code_allocator #(
    parameter int unsigned MAX_CODE  = pca_pkg::MAX_CODE_DEFAULT,
    parameter int unsigned MAX_BURST = pca_pkg::MAX_BURST_DEFAULT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  pca_pkg::t_item   i_item,
    output logic             o_busy,
    output logic             o_valid,
    output pca_pkg::t_result o_result
);

    pca_pkg::t_cmd cmd;

    pca_ctrl #(
        .MAX_BURST(MAX_BURST)
    ) u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .i_item (i_item),
        .o_busy (o_busy),
        .o_cmd  (cmd)
    );

    pca_datapath #(
        .MAX_CODE(MAX_CODE)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_code  (i_item.code),
        .o_valid (o_valid),
        .o_result(o_result)
    );

    a_free_one_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_item.opcode == pca_pkg::OP_FREE) |=>
            (o_valid && o_result.last))
        else $error("free item did not give a single last beat");

    a_exhausted_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result.status == pca_pkg::ST_EXHAUSTED) |-> (o_result.code_out == '0))
        else $error("exhausted beat carries a nonzero code");

    a_burst_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(o_busy) |-> (o_valid && o_result.last))
        else $error("allocate burst ended without a last beat");

endmodule
